FILE: rtl/tars_pkg.sv
// ----------------------------------------------------------------------------
// tars_pkg - shared types and constants for the tensor axis sum reduction
// Store sizing, item layout between front and back, mode and register codes.
// ----------------------------------------------------------------------------
package tars_pkg;

  // Sizing
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned DIM_BITS    = 16;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned PART_W      = IDX_W + 1;
  localparam int unsigned PROD_W      = DIM_BITS + PART_W;
  localparam int unsigned HW_W        = 2 * DIM_BITS;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = (DIM_BITS > 3) ? DIM_BITS : 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reduction modes: axes summed away
  typedef enum logic [2:0] {
    MODE_N   = 3'd0,
    MODE_C   = 3'd1,
    MODE_H   = 3'd2,
    MODE_W   = 3'd3,
    MODE_NC  = 3'd4,
    MODE_CH  = 3'd5,
    MODE_HW  = 3'd6,
    MODE_ALL = 3'd7
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 3'd0,
    REG_BATCH   = 3'd1,
    REG_CHANNEL = 3'd2,
    REG_HEIGHT  = 3'd3,
    REG_WIDTH   = 3'd4
  } cfg_reg_e;

  // Classified item handed from front to back
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             first;
    logic             last;
    logic             use_store;
    logic             err;
    logic             tensor_end;
    logic [IDX_W-1:0] idx;
  } item_t;

endpackage

FILE: rtl/tars_if.sv
// ----------------------------------------------------------------------------
// tars_if - valid/ready channels of the tensor axis sum reduction
// Input channel carries one tensor element, output channel one finished sum.
// ----------------------------------------------------------------------------
interface tars_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [tars_pkg::VAL_W-1:0]  value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

interface tars_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tars_pkg::VAL_W-1:0]  sum_out;
  logic                               out_last;
  logic                               config_error;

  modport source (output valid, output sum_out, output out_last, output config_error,
                  input ready);
  modport sink   (input valid, input sum_out, input out_last, input config_error,
                  output ready);
endinterface

FILE: rtl/tars_front.sv
// ----------------------------------------------------------------------------
// tars_front - configuration, position tracking and item classification
// Holds the tensor extents and mode, walks the N,C,H,W position and tags each
// item with first/last slice, store index and plane-size error.
// ----------------------------------------------------------------------------
module tars_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tars_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tars_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tars_in_if.sink                         in_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output tars_pkg::item_t                 push_item_o
);
  import tars_pkg::*;

  mode_e               mode_q;
  logic [DIM_BITS-1:0] dim_b_q, dim_c_q, dim_h_q, dim_w_q;
  logic [DIM_BITS-1:0] pos_b_q, pos_c_q, pos_r_q, pos_w_q;
  logic [DIM_BITS-1:0] pos_b_d, pos_c_d, pos_r_d, pos_w_d;
  logic [IDX_W-1:0]    pidx_q, pidx_d;
  logic [1:0]          busy_q;
  logic [HW_W-1:0]     hw_q;
  logic                err_chw_q, err_hw_q, err_w_q;
  logic [DIM_BITS-1:0] eff_b, eff_c, eff_h, eff_w;
  logic [PART_W-1:0]   hw_part;
  logic [PROD_W-1:0]   chw_prod;
  logic                hw_gt;
  logic                fb, lb, fc, lc, fr, lr, fw, lw;
  logic                first, last, use_store, err, tensor_end, wrap;
  logic                accept;

  // Zero extents act as one
  assign eff_b = (dim_b_q == '0) ? DIM_BITS'(1) : dim_b_q;
  assign eff_c = (dim_c_q == '0) ? DIM_BITS'(1) : dim_c_q;
  assign eff_h = (dim_h_q == '0) ? DIM_BITS'(1) : dim_h_q;
  assign eff_w = (dim_w_q == '0) ? DIM_BITS'(1) : dim_w_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ALL;
      dim_b_q <= DIM_BITS'(1);
      dim_c_q <= DIM_BITS'(1);
      dim_h_q <= DIM_BITS'(1);
      dim_w_q <= DIM_BITS'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:    mode_q  <= mode_e'(cfg_data_i[2:0]);
        REG_BATCH:   dim_b_q <= DIM_BITS'(cfg_data_i);
        REG_CHANNEL: dim_c_q <= DIM_BITS'(cfg_data_i);
        REG_HEIGHT:  dim_h_q <= DIM_BITS'(cfg_data_i);
        REG_WIDTH:   dim_w_q <= DIM_BITS'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Plane size checks: two registered steps after any write
  assign hw_gt    = 64'(hw_q) > 64'(STORE_DEPTH);
  assign hw_part  = PART_W'(hw_q);
  assign chw_prod = PROD_W'(eff_c) * PROD_W'(hw_part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q      <= HW_W'(1);
      err_chw_q <= 1'b0;
      err_hw_q  <= 1'b0;
      err_w_q   <= 1'b0;
      busy_q    <= '0;
    end else begin
      hw_q      <= HW_W'(eff_h) * HW_W'(eff_w);
      err_chw_q <= hw_gt || (64'(chw_prod) > 64'(STORE_DEPTH));
      err_hw_q  <= hw_gt;
      err_w_q   <= 64'(eff_w) > 64'(STORE_DEPTH);
      // hold off items until the checks have settled
      if (cfg_we_i && (cfg_idx_i <= CFG_IDX_W'(REG_WIDTH))) begin
        busy_q <= 2'b11;
      end else begin
        busy_q <= {1'b0, busy_q[1]};
      end
    end
  end

  // Position flags
  assign fb = pos_b_q == '0;
  assign fc = pos_c_q == '0;
  assign fr = pos_r_q == '0;
  assign fw = pos_w_q == '0;
  assign lb = pos_b_q == (eff_b - DIM_BITS'(1));
  assign lc = pos_c_q == (eff_c - DIM_BITS'(1));
  assign lr = pos_r_q == (eff_h - DIM_BITS'(1));
  assign lw = pos_w_q == (eff_w - DIM_BITS'(1));

  // Classify the item by mode
  always_comb begin
    use_store  = 1'b1;
    err        = 1'b0;
    wrap       = 1'b1;
    tensor_end = (mode_q == MODE_ALL) ? lw : (lb && lc && lr && lw);
    unique case (mode_q)
      MODE_N: begin
        first = fb;        last = lb;
        err   = err_chw_q; wrap = lc && lr && lw;
      end
      MODE_C: begin
        first = fc;        last = lc;
        err   = err_hw_q;  wrap = lr && lw;
      end
      MODE_H: begin
        first = fr;        last = lr;
        err   = err_w_q;   wrap = lw;
      end
      MODE_NC: begin
        first = fb && fc;  last = lb && lc;
        err   = err_hw_q;  wrap = lr && lw;
      end
      MODE_CH: begin
        first = fc && fr;  last = lc && lr;
        err   = err_w_q;   wrap = lw;
      end
      MODE_HW: begin
        first = fr && fw;  last = lr && lw;
        use_store = 1'b0;
      end
      default: begin
        first = fw;        last = lw;
        use_store = 1'b0;
      end
    endcase
  end

  // Advance the position
  always_comb begin
    pos_b_d = pos_b_q;
    pos_c_d = pos_c_q;
    pos_r_d = pos_r_q;
    pos_w_d = pos_w_q;
    pidx_d  = wrap ? '0 : pidx_q + IDX_W'(1);
    if (mode_q == MODE_ALL) begin
      pos_w_d = lw ? '0 : pos_w_q + DIM_BITS'(1);
      pos_r_d = '0;
      pos_c_d = '0;
      pos_b_d = '0;
    end else if (!lw) begin
      pos_w_d = pos_w_q + DIM_BITS'(1);
    end else begin
      pos_w_d = '0;
      if (!lr) begin
        pos_r_d = pos_r_q + DIM_BITS'(1);
      end else begin
        pos_r_d = '0;
        if (!lc) begin
          pos_c_d = pos_c_q + DIM_BITS'(1);
        end else begin
          pos_c_d = '0;
          pos_b_d = lb ? '0 : pos_b_q + DIM_BITS'(1);
        end
      end
    end
  end

  assign in_i.ready = !q_full_i && (busy_q == '0);
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_b_q <= '0;
      pos_c_q <= '0;
      pos_r_q <= '0;
      pos_w_q <= '0;
      pidx_q  <= '0;
    end else if (cfg_we_i && (cfg_idx_i <= CFG_IDX_W'(REG_WIDTH))) begin
      // restart the tensor
      pos_b_q <= '0;
      pos_c_q <= '0;
      pos_r_q <= '0;
      pos_w_q <= '0;
      pidx_q  <= '0;
    end else if (accept) begin
      pos_b_q <= pos_b_d;
      pos_c_q <= pos_c_d;
      pos_r_q <= pos_r_d;
      pos_w_q <= pos_w_d;
      pidx_q  <= pidx_d;
    end
  end

  assign push_o                 = accept;
  assign push_item_o.value      = in_i.value_in;
  assign push_item_o.first      = first;
  assign push_item_o.last       = last;
  assign push_item_o.use_store  = use_store;
  assign push_item_o.err        = err;
  assign push_item_o.tensor_end = tensor_end;
  assign push_item_o.idx        = pidx_q;

endmodule

FILE: rtl/tars_queue.sv
// ----------------------------------------------------------------------------
// tars_queue - short item queue between front and back
// Lets the front keep taking items while the back waits on the output.
// ----------------------------------------------------------------------------
module tars_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tars_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output tars_pkg::item_t item_o
);
  import tars_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = entry_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill level out of range");

endmodule

FILE: rtl/tars_back.sv
// ----------------------------------------------------------------------------
// tars_back - accumulation and result output
// Read-modify-write of the partial sum store or the running register, with
// forwarding for back-to-back hits, and a registered output stage.
// ----------------------------------------------------------------------------
module tars_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  tars_pkg::item_t q_item_i,
  output logic            pop_o,
  tars_out_if.source      out_o
);
  import tars_pkg::*;

  logic [VAL_W-1:0] mem [STORE_DEPTH];
  item_t            s2_q;
  logic             s2_valid_q;
  logic [VAL_W-1:0] rdata_q;
  logic             fwd_hit_q;
  logic [VAL_W-1:0] fwd_val_q;
  logic [VAL_W-1:0] running_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_sum_q;
  logic             out_last_q;
  logic             out_err_q;
  logic [VAL_W-1:0] prev;
  logic [VAL_W-1:0] s2_sum;
  logic             s2_fire;
  logic             s2_write;
  logic             out_free;

  // Pick the earlier partial sum
  always_comb begin
    if (s2_q.first) begin
      prev = '0;
    end else if (!s2_q.use_store) begin
      prev = running_q;
    end else if (fwd_hit_q) begin
      prev = fwd_val_q;
    end else begin
      prev = rdata_q;
    end
  end

  assign s2_sum   = prev + s2_q.value;
  assign out_free = !out_valid_q || out_o.ready;
  assign s2_fire  = s2_valid_q && (!s2_q.last || out_free);
  assign s2_write = s2_fire && s2_q.use_store && !s2_q.err;
  assign pop_o    = q_valid_i && (!s2_valid_q || s2_fire);

  // Partial sum store: write back and read ahead
  always_ff @(posedge clk_i) begin
    if (s2_write) begin
      mem[s2_q.idx] <= s2_sum;
    end
    if (pop_o) begin
      rdata_q <= mem[q_item_i.idx];
    end
  end

  // Load the accumulate stage; catch a write to the entry being read
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_q      <= q_item_i;
      fwd_hit_q <= s2_write && (s2_q.idx == q_item_i.idx);
      fwd_val_q <= s2_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      running_q  <= '0;
    end else begin
      if (pop_o) begin
        s2_valid_q <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_fire && !s2_q.use_store) begin
        running_q <= s2_sum;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire && s2_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire && s2_q.last) begin
      out_sum_q  <= s2_q.err ? '0 : s2_sum;
      out_last_q <= s2_q.tensor_end;
      out_err_q  <= s2_q.err;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sum_out      = out_sum_q;
  assign out_o.out_last     = out_last_q;
  assign out_o.config_error = out_err_q;

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i)
    else $error("accumulate stage loaded from an empty queue");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_write |-> ({1'b0, s2_q.idx} < PART_W'(STORE_DEPTH)))
    else $error("store write beyond depth");

  a_err_only_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_q.use_store) |-> !s2_q.err)
    else $error("error flag on a running-register item");

  a_result_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && s2_q.last) |=> out_valid_q)
    else $error("finished sum not presented");

endmodule

FILE: rtl/tensor_axis_reduce_sum.sv
// ----------------------------------------------------------------------------
// tensor_axis_reduce_sum - streaming integer sum over selected NCHW axes
// Front tracks position and classifies, a short queue decouples it from the
// back, which accumulates in a partial sum store or running register.
// ----------------------------------------------------------------------------
//  channel   dir  payload                               handshake
//  in_i      in   value_in                              valid/ready
//  out_o     out  sum_out, out_last, config_error       valid/ready
//  cfg       in   cfg_idx_i, cfg_data_i                 cfg_we_i, no stall
//
//  Sustained rate is one item per cycle while no output stall or register
//  write holds the input; the store does one read and one write per cycle,
//  with a forward path for repeated hits on one entry. After a register write,
//  in_i.ready stays low while the plane size checks settle. The store needs no
//  clearing after reset. An output stall fills the two-entry queue, then
//  in_i.ready drops.
// ----------------------------------------------------------------------------
module tensor_axis_reduce_sum (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tars_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tars_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tars_in_if.sink                         in_i,
  tars_out_if.source                      out_o
);
  import tars_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  tars_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  tars_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  tars_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
